[rtl/kli_pkg.sv]
// ----------------------------------------------------------------------------
// kli_pkg
// Shared types and constants of the keyframe linear interpolator.
// ----------------------------------------------------------------------------
package kli_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;

    typedef logic [2:0][DATA_W-1:0] t_vec3;

    typedef enum logic [1:0] {
        ST_INTERP = 2'd0,
        ST_FIRST  = 2'd1,
        ST_LAST   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_FIRST,
        BS_SCAN,
        BS_DIV,
        BS_MUL,
        BS_ADD,
        BS_EMIT
    } t_bstate;

    // One queued word between the front and the back. The time field carries
    // the key time of a write or the sample time of a sample.
    typedef struct packed {
        logic              is_sample;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] tm;
        t_vec3             val;
    } t_cmd;

    typedef struct packed {
        t_vec3   val;
        t_status status;
    } t_result;

endpackage

[rtl/kli_ram.sv]
// ----------------------------------------------------------------------------
// kli_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kli_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/kli_fifo.sv]
// ----------------------------------------------------------------------------
// kli_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module kli_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [PW:0]   r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH-1)) ? '0 : PW'(r_wp + 1'b1);
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH-1)) ? '0 : PW'(r_rp + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_cnt = (PW+1)'(r_cnt + 1'b1);
        end else if (do_pop && !do_push) begin
            n_cnt = (PW+1)'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[rtl/kli_front.sv]
// ----------------------------------------------------------------------------
// kli_front
// Accepts input words, drops key writes aimed past the table, and queues the
// rest as commands for the back end.
// ----------------------------------------------------------------------------
module kli_front #(
    parameter int MAX_KEYS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        i_mode,
    input  logic [kli_pkg::IDX_W-1:0]   i_key_index,
    input  logic [kli_pkg::DATA_W-1:0]  i_key_time,
    input  kli_pkg::t_vec3              i_key_val,
    input  logic [kli_pkg::DATA_W-1:0]  i_sample_time,
    input  logic                        i_cmd_pop,
    output kli_pkg::t_cmd               o_cmd,
    output logic                        o_cmd_empty
);

    import kli_pkg::*;

    t_cmd cmd_in;
    logic keep;
    logic [$bits(t_cmd)-1:0] cmd_bits;

    // A sample is always kept; a write only when its slot exists.
    assign keep = i_mode || (int'(i_key_index) < MAX_KEYS);

    always_comb begin
        cmd_in.is_sample = i_mode;
        cmd_in.idx       = i_key_index;
        cmd_in.tm        = i_mode ? i_sample_time : i_key_time;
        cmd_in.val       = i_key_val;
    end

    kli_fifo #(
        .W     ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && keep),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (i_cmd_pop),
        .o_data  (cmd_bits),
        .o_empty (o_cmd_empty)
    );

    assign o_cmd = t_cmd'(cmd_bits);

endmodule

[rtl/kli_back.sv]
// ----------------------------------------------------------------------------
// kli_back
// Executes queued commands: stores keys, scans the table for the bracketing
// segment, divides for the weight one bit a cycle, and blends component by
// component on one shared multiplier.
// ----------------------------------------------------------------------------
module kli_back #(
    parameter int MAX_KEYS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [kli_pkg::CNT_W-1:0]  i_count,
    input  kli_pkg::t_cmd              i_cmd,
    input  logic                       i_cmd_empty,
    output logic                       o_cmd_pop,
    output logic                       o_res_push,
    output kli_pkg::t_result           o_res,
    input  logic                       i_res_full
);

    import kli_pkg::*;

    localparam int AW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int QW  = FRAC_BITS + 1;
    localparam int DCW = $clog2(FRAC_BITS + 1);
    localparam int PRW = DATA_W + 1 + QW + 1;

    t_bstate r_state, n_state;

    logic [DATA_W-1:0] r_ts, r_tprev, r_span;
    t_vec3             r_vprev, r_v1, r_res;
    t_status           r_status;
    logic [CNT_W-1:0]  r_n, r_k, k_next;
    logic [DATA_W:0]   r_rem;
    logic [QW-1:0]     r_q;
    logic [DCW-1:0]    r_dcnt;
    logic [1:0]        r_c;
    logic signed [PRW-1:0] r_prod;

    logic [DATA_W-1:0]  t_rd;
    logic [3*DATA_W-1:0] v_rd_bits;
    t_vec3              v_rd;
    logic               we;
    logic [AW-1:0]      waddr, raddr;

    logic              hit, ge;
    logic [DATA_W-1:0] span, rem_sub;
    logic [DATA_W-1:0] a_cur, b_cur;
    logic signed [DATA_W:0]  d_sel;
    logic signed [PRW-1:0]   a_ext, sum;

    kli_ram #(.W(DATA_W), .DEPTH(MAX_KEYS)) u_times (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_cmd.tm),
        .i_raddr (raddr),
        .o_rdata (t_rd)
    );

    kli_ram #(.W(3*DATA_W), .DEPTH(MAX_KEYS)) u_values (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_cmd.val),
        .i_raddr (raddr),
        .o_rdata (v_rd_bits)
    );

    assign v_rd   = t_vec3'(v_rd_bits);
    assign k_next = CNT_W'(r_k + 1'b1);
    assign span   = t_rd - r_tprev;
    assign hit    = (r_tprev <= r_ts) && (r_ts <= t_rd);

    // Restoring division step; the remainder left by each step stays below the span.
    assign ge      = (r_rem >= {1'b0, r_span});
    assign rem_sub = ge ? DATA_W'(r_rem - {1'b0, r_span}) : r_rem[DATA_W-1:0];

    assign a_cur = r_vprev[r_c];
    assign b_cur = r_v1[r_c];
    assign d_sel = $signed({b_cur[DATA_W-1], b_cur}) - $signed({a_cur[DATA_W-1], a_cur});
    assign a_ext = PRW'($signed(a_cur));
    assign sum   = a_ext + (r_prod >>> FRAC_BITS);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (!i_cmd_empty && i_cmd.is_sample) begin
                    n_state = (i_count == '0) ? BS_EMIT : BS_FIRST;
                end
            end
            BS_FIRST: begin
                if ((r_n == CNT_W'(1)) || (r_ts <= t_rd)) begin
                    n_state = BS_EMIT;
                end else begin
                    n_state = BS_SCAN;
                end
            end
            BS_SCAN: begin
                if (hit) begin
                    n_state = (span == '0) ? BS_EMIT : BS_DIV;
                end else if (k_next == r_n) begin
                    n_state = BS_EMIT;
                end
            end
            BS_DIV: begin
                if (r_dcnt == DCW'(FRAC_BITS)) begin
                    n_state = BS_MUL;
                end
            end
            BS_MUL: n_state = BS_ADD;
            BS_ADD: begin
                if (r_c == 2'd2) begin
                    n_state = BS_EMIT;
                end else begin
                    n_state = BS_MUL;
                end
            end
            BS_EMIT: begin
                if (!i_res_full) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        we         = 1'b0;
        raddr      = '0;
        waddr      = AW'(i_cmd.idx);
        unique case (r_state)
            BS_IDLE: begin
                o_cmd_pop = !i_cmd_empty;
                we        = !i_cmd_empty && !i_cmd.is_sample;
            end
            BS_FIRST, BS_SCAN: raddr = AW'(k_next);
            BS_EMIT:  o_res_push = !i_res_full;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BS_IDLE: begin
                r_k      <= '0;
                r_ts     <= i_cmd.tm;
                r_n      <= i_count;
                r_res    <= '0;
                r_status <= ST_EMPTY;
            end
            BS_FIRST: begin
                r_tprev  <= t_rd;
                r_vprev  <= v_rd;
                r_res    <= v_rd;
                r_status <= ST_FIRST;
                r_k      <= CNT_W'(1);
            end
            BS_SCAN: begin
                if (hit) begin
                    // A zero-length segment leaves the start value in place.
                    r_v1     <= v_rd;
                    r_span   <= span;
                    r_rem    <= {1'b0, r_ts - r_tprev};
                    r_q      <= '0;
                    r_dcnt   <= '0;
                    r_c      <= '0;
                    r_res    <= r_vprev;
                    r_status <= ST_INTERP;
                end else begin
                    r_tprev  <= t_rd;
                    r_vprev  <= v_rd;
                    r_res    <= v_rd;
                    r_status <= ST_LAST;
                    r_k      <= k_next;
                end
            end
            BS_DIV: begin
                r_rem  <= {rem_sub, 1'b0};
                r_q    <= {r_q[QW-2:0], ge};
                r_dcnt <= DCW'(r_dcnt + 1'b1);
            end
            BS_MUL: begin
                r_prod <= PRW'(d_sel) * PRW'($signed({1'b0, r_q}));
            end
            BS_ADD: begin
                r_res[r_c] <= sum[DATA_W-1:0];
                r_c        <= 2'(r_c + 1'b1);
            end
            default: ;
        endcase
    end

    always_comb begin
        o_res.val    = r_res;
        o_res.status = r_status;
    end

endmodule

[rtl/keyframe_linear_interpolator_core.sv]
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_core
// Piecewise linear keyframe interpolation over a table of keys, Q16.16.
//
// Channel   Direction  Handshake             Word
// input     in         push / full           mode, key fields, sample time
// result    out        empty / pop           out_x, out_y, out_z, status
// config    in         cfg_valid / cfg_ready key_count
//
// A key write is stored as the back end pops it. For a sample resolved in a
// segment, the table scan reads one key a cycle from the key RAMs, the
// divider yields one weight bit a cycle, and one multiplier serves the three
// components. Held samples finish after the scan alone.
// Reset clears the queues and the key count; the key RAMs keep their contents.
// A two-deep command queue and a two-deep result queue let each side stall.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator_core #(
    parameter int MAX_KEYS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              i_mode,
    input  logic [kli_pkg::IDX_W-1:0]         i_key_index,
    input  logic [kli_pkg::DATA_W-1:0]        i_key_time,
    input  logic signed [kli_pkg::DATA_W-1:0] i_key_x,
    input  logic signed [kli_pkg::DATA_W-1:0] i_key_y,
    input  logic signed [kli_pkg::DATA_W-1:0] i_key_z,
    input  logic [kli_pkg::DATA_W-1:0]        i_sample_time,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [kli_pkg::DATA_W-1:0] o_out_x,
    output logic signed [kli_pkg::DATA_W-1:0] o_out_y,
    output logic signed [kli_pkg::DATA_W-1:0] o_out_z,
    output logic [1:0]                        o_sample_status,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [kli_pkg::CNT_W-1:0]         i_cfg_data
);

    import kli_pkg::*;

    localparam int NCLAMP = (MAX_KEYS < 127) ? MAX_KEYS : 127;

    logic [CNT_W-1:0] r_key_count, count_eff;
    t_vec3            key_val;
    t_cmd             cmd;
    logic             cmd_empty, cmd_pop;
    t_result          res_in, res_out;
    logic [$bits(t_result)-1:0] res_bits;
    logic             res_push, res_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
        end else if (i_cfg_valid) begin
            r_key_count <= i_cfg_data;
        end
    end

    // A count above the table size acts as the table size.
    assign count_eff = (r_key_count > CNT_W'(NCLAMP)) ? CNT_W'(NCLAMP) : r_key_count;

    always_comb begin
        key_val[0] = i_key_x;
        key_val[1] = i_key_y;
        key_val[2] = i_key_z;
    end

    kli_front #(.MAX_KEYS(MAX_KEYS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_mode        (i_mode),
        .i_key_index   (i_key_index),
        .i_key_time    (i_key_time),
        .i_key_val     (key_val),
        .i_sample_time (i_sample_time),
        .i_cmd_pop     (cmd_pop),
        .o_cmd         (cmd),
        .o_cmd_empty   (cmd_empty)
    );

    kli_back #(.MAX_KEYS(MAX_KEYS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_count     (count_eff),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    kli_fifo #(.W($bits(t_result)), .DEPTH(2)) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_bits),
        .o_empty (empty)
    );

    assign res_out         = t_result'(res_bits);
    assign o_out_x         = $signed(res_out.val[0]);
    assign o_out_y         = $signed(res_out.val[1]);
    assign o_out_z         = $signed(res_out.val[2]);
    assign o_sample_status = res_out.status;

`ifndef NO_ASSERTIONS
    // The back end must hold its word while the result queue is full.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res_push && res_full))
        else $error("result pushed into a full queue");

    // An empty table always reads as zero.
    a_empty_table_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_sample_status == ST_EMPTY)) |->
            ((o_out_x == '0) && (o_out_y == '0) && (o_out_z == '0)))
        else $error("empty-table word carries a nonzero value");

    // No result word survives a reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> empty)
        else $error("result queue not empty after reset");
`endif

endmodule
